// File: rtl/bqc_pkg.sv
// ----------------------------------------------------------------------------
// Biquad cascade package
// Field widths, operation codes, step codes of the control program, the
// control word and status bundle, and the control program itself.
// ----------------------------------------------------------------------------
package bqc_pkg;

    // Word field widths
    localparam int OP_W        = 2;
    localparam int SEC_FIELD_W = 3;
    localparam int SLOT_W      = 3;
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = 4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_FILTER     = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_COEF  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD_DELAY = 2'd2;
    localparam logic [OP_W-1:0] OP_READ_DELAY = 2'd3;

    // Section layout and number formats
    localparam int COEFS     = 5;
    localparam int DELAYS    = 2;
    localparam int COEF_FRAC = 28;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + 2;

    // Coefficient slots
    localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

    // Step codes of the control program
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_CLR  = 4'd0;
    localparam logic [STEP_W-1:0] ST_IDLE = 4'd1;
    localparam logic [STEP_W-1:0] ST_DISP = 4'd2;
    localparam logic [STEP_W-1:0] ST_PRE  = 4'd3;
    localparam logic [STEP_W-1:0] ST_S0   = 4'd4;
    localparam logic [STEP_W-1:0] ST_S1   = 4'd5;
    localparam logic [STEP_W-1:0] ST_S2   = 4'd6;
    localparam logic [STEP_W-1:0] ST_S3   = 4'd7;
    localparam logic [STEP_W-1:0] ST_S4   = 4'd8;
    localparam logic [STEP_W-1:0] ST_FIN  = 4'd9;
    localparam logic [STEP_W-1:0] ST_RD0  = 4'd10;
    localparam logic [STEP_W-1:0] ST_RD1  = 4'd11;

    // Jump kinds
    localparam int JMP_W = 3;
    localparam logic [JMP_W-1:0] JMP_NEXT   = 3'd0;
    localparam logic [JMP_W-1:0] JMP_GOTO   = 3'd1;
    localparam logic [JMP_W-1:0] JMP_CLR    = 3'd2;
    localparam logic [JMP_W-1:0] JMP_ACCEPT = 3'd3;
    localparam logic [JMP_W-1:0] JMP_DISP   = 3'd4;
    localparam logic [JMP_W-1:0] JMP_LAST   = 3'd5;
    localparam logic [JMP_W-1:0] JMP_OUT    = 3'd6;

    // Main accumulator operations
    localparam int ACC_OP_W = 3;
    localparam logic [ACC_OP_W-1:0] ACC_HOLD     = 3'd0;
    localparam logic [ACC_OP_W-1:0] ACC_LOAD_DLY = 3'd1;
    localparam logic [ACC_OP_W-1:0] ACC_ADD      = 3'd2;
    localparam logic [ACC_OP_W-1:0] ACC_DLY_ADD  = 3'd3;
    localparam logic [ACC_OP_W-1:0] ACC_SUB      = 3'd4;

    // Second accumulator operations
    localparam int ACC1_OP_W = 2;
    localparam logic [ACC1_OP_W-1:0] ACC1_HOLD = 2'd0;
    localparam logic [ACC1_OP_W-1:0] ACC1_LOAD = 2'd1;
    localparam logic [ACC1_OP_W-1:0] ACC1_SUB  = 2'd2;

    // One control word of the program
    typedef struct packed {
        logic [JMP_W-1:0]     jmp;
        logic [STEP_W-1:0]    target;
        logic                 ready;
        logic                 disp_wr;
        logic                 clr;
        logic                 init;
        logic                 coef_rd;
        logic [SLOT_W-1:0]    coef_slot;
        logic                 dly_rd;
        logic                 dly_slot;
        logic                 rd_next;
        logic                 rd_item;
        logic [ACC_OP_W-1:0]  acc_op;
        logic [ACC1_OP_W-1:0] acc1_op;
        logic                 mul_y;
        logic                 rnd_alt;
        logic                 y_ld;
        logic                 z_wr;
        logic                 z_slot;
        logic                 adv;
        logic                 rd_load;
        logic                 push;
    } ctl_t;

    // Status returned from the datapath to the sequencer
    typedef struct packed {
        logic            clr_done;
        logic            last;
        logic            out_free;
        logic [OP_W-1:0] op;
    } stat_t;

    // The control program. Per section the five steps S0..S4 repeat; the
    // writeback of a section's delays overlaps the next section's first two
    // steps, so after the last section S0 and S1 run once more as a tail.
    function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
        ctl_t w;
        w        = '0;
        w.jmp    = JMP_GOTO;
        w.target = ST_IDLE;
        unique case (step)
            ST_CLR:
            begin
                w.clr    = 1'b1;
                w.jmp    = JMP_CLR;
                w.target = ST_IDLE;
            end
            ST_IDLE:
            begin
                w.ready  = 1'b1;
                w.jmp    = JMP_ACCEPT;
                w.target = ST_DISP;
            end
            ST_DISP:
            begin
                w.disp_wr = 1'b1;
                w.jmp     = JMP_DISP;
            end
            ST_PRE:
            begin
                w.init      = 1'b1;
                w.coef_rd   = 1'b1;
                w.coef_slot = SLOT_B0;
                w.dly_rd    = 1'b1;
                w.dly_slot  = 1'b0;
                w.jmp       = JMP_NEXT;
            end
            ST_S0:
            begin
                w.acc_op    = ACC_LOAD_DLY;
                w.acc1_op   = ACC1_SUB;
                w.coef_rd   = 1'b1;
                w.coef_slot = SLOT_B1;
                w.dly_rd    = 1'b1;
                w.dly_slot  = 1'b1;
                w.z_wr      = 1'b1;
                w.z_slot    = 1'b0;
                w.jmp       = JMP_NEXT;
            end
            ST_S1:
            begin
                w.acc_op    = ACC_ADD;
                w.coef_rd   = 1'b1;
                w.coef_slot = SLOT_B2;
                w.rnd_alt   = 1'b1;
                w.z_wr      = 1'b1;
                w.z_slot    = 1'b1;
                w.jmp       = JMP_LAST;
                w.target    = ST_FIN;
            end
            ST_S2:
            begin
                w.y_ld      = 1'b1;
                w.acc_op    = ACC_DLY_ADD;
                w.coef_rd   = 1'b1;
                w.coef_slot = SLOT_A1;
                w.jmp       = JMP_NEXT;
            end
            ST_S3:
            begin
                w.acc1_op   = ACC1_LOAD;
                w.mul_y     = 1'b1;
                w.coef_rd   = 1'b1;
                w.coef_slot = SLOT_A2;
                w.jmp       = JMP_NEXT;
            end
            ST_S4:
            begin
                w.acc_op    = ACC_SUB;
                w.mul_y     = 1'b1;
                w.coef_rd   = 1'b1;
                w.coef_slot = SLOT_B0;
                w.dly_rd    = 1'b1;
                w.dly_slot  = 1'b0;
                w.rd_next   = 1'b1;
                w.adv       = 1'b1;
                w.jmp       = JMP_GOTO;
                w.target    = ST_S0;
            end
            ST_FIN:
            begin
                w.push   = 1'b1;
                w.jmp    = JMP_OUT;
                w.target = ST_IDLE;
            end
            ST_RD0:
            begin
                w.dly_rd  = 1'b1;
                w.rd_item = 1'b1;
                w.jmp     = JMP_NEXT;
            end
            ST_RD1:
            begin
                w.rd_load = 1'b1;
                w.jmp     = JMP_GOTO;
                w.target  = ST_FIN;
            end
            default:
            begin
                w.jmp    = JMP_GOTO;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/bqc_item_if.sv
// ----------------------------------------------------------------------------
// Biquad cascade input channel
// Valid/ready channel carrying one command word: operation, section, slot
// and value.
// ----------------------------------------------------------------------------
interface bqc_item_if;
    logic                                  valid;
    logic                                  ready;
    logic [bqc_pkg::OP_W-1:0]              op;
    logic [bqc_pkg::SEC_FIELD_W-1:0]       section;
    logic [bqc_pkg::SLOT_W-1:0]            slot;
    logic signed [bqc_pkg::DATA_W-1:0]     value;

    modport source (output valid, output op, output section, output slot, output value,
                    input ready);
    modport sink (input valid, input op, input section, input slot, input value,
                  output ready);
endinterface

// File: rtl/bqc_result_if.sv
// ----------------------------------------------------------------------------
// Biquad cascade result channel
// Valid/ready channel carrying one result word: data and saturation flag.
// ----------------------------------------------------------------------------
interface bqc_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [bqc_pkg::DATA_W-1:0] data;
    logic                              saturated;

    modport source (output valid, output data, output saturated, input ready);
    modport sink (input valid, input data, input saturated, output ready);
endinterface

// File: rtl/bqc_sequencer.sv
// ----------------------------------------------------------------------------
// Biquad cascade sequencer
// Step counter over the control program, with conditional jumps on the
// handshake, the operation code, the clearing pass and the section loop.
// ----------------------------------------------------------------------------
module bqc_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  bqc_pkg::stat_t  stat,
    output bqc_pkg::ctl_t   ctl
);
    import bqc_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] step_inc;

    // Current control word straight from the program table.
    assign ctl      = ucode(step_reg);
    assign step_inc = step_reg + STEP_W'(1);

    // Next step selection.
    always_comb
    begin
        unique case (ctl.jmp)
            JMP_NEXT:   step_next = step_inc;
            JMP_GOTO:   step_next = ctl.target;
            JMP_CLR:    step_next = stat.clr_done ? ctl.target : step_reg;
            JMP_ACCEPT: step_next = in_valid ? ctl.target : step_reg;
            JMP_LAST:   step_next = stat.last ? ctl.target : step_inc;
            JMP_OUT:    step_next = stat.out_free ? ctl.target : step_reg;
            JMP_DISP:
            begin
                priority if (stat.op == OP_FILTER)
                    step_next = ST_PRE;
                else if (stat.op == OP_READ_DELAY)
                    step_next = ST_RD0;
                else
                    step_next = ST_IDLE;
            end
            default:    step_next = ST_IDLE;
        endcase
    end

    // Step counter; reset starts the memory clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= ST_CLR;
        else
            step_reg <= step_next;
    end

    // The section loop leaves through the writeback tail into the result step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_S1 && stat.last) |=> step_reg == ST_FIN)
        else $error("section loop did not end in the result step");

    // A result step holds while the output register is still occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_FIN && !stat.out_free) |=> step_reg == ST_FIN)
        else $error("result step left with the output register full");

    // A word offered while idle is taken and dispatched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_IDLE && in_valid) |=> step_reg == ST_DISP)
        else $error("offered word not dispatched");

endmodule

// File: rtl/bqc_datapath.sv
// ----------------------------------------------------------------------------
// Biquad cascade datapath
// Coefficient and delay memories, one registered 32x32 multiplier, two
// accumulators, a shared round-and-saturate unit and the output register,
// all driven by the sequencer's control word.
// ----------------------------------------------------------------------------
module bqc_datapath #(
    parameter int SECTIONS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bqc_pkg::ctl_t                       ctl,
    output bqc_pkg::stat_t                      stat,
    input  logic                                in_valid,
    input  logic [bqc_pkg::OP_W-1:0]            in_op,
    input  logic [bqc_pkg::SEC_FIELD_W-1:0]     in_section,
    input  logic [bqc_pkg::SLOT_W-1:0]          in_slot,
    input  logic signed [bqc_pkg::DATA_W-1:0]   in_value,
    input  logic                                cfg_we,
    input  logic [bqc_pkg::COUNT_W-1:0]         cfg_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [bqc_pkg::DATA_W-1:0]   out_data,
    output logic                                out_saturated
);
    import bqc_pkg::*;

    localparam int CDEPTH  = SECTIONS * COEFS;
    localparam int DDEPTH  = SECTIONS * DELAYS;
    localparam int CADDR_W = $clog2(CDEPTH);
    localparam int DADDR_W = $clog2(DDEPTH);
    localparam int SEC_W   = $clog2(SECTIONS + 1);
    localparam int W_S     = (SEC_W > COUNT_W) ? SEC_W : COUNT_W;
    localparam int IDX_W   = W_S + 3;
    localparam int Q_W     = ACC_W - COEF_FRAC;

    localparam logic [W_S-1:0]            SEC_LIM  = W_S'(SECTIONS);
    localparam logic [CADDR_W-1:0]        CLR_LAST = CADDR_W'(CDEPTH - 1);
    localparam logic [CADDR_W-1:0]        DLY_END  = CADDR_W'(DDEPTH);
    localparam logic signed [ACC_W-1:0]   RND_HALF = ACC_W'(1) << (COEF_FRAC - 1);
    localparam logic signed [Q_W-1:0]     Q_MAX    =
        {{(Q_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [Q_W-1:0]     Q_MIN    =
        {{(Q_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};
    localparam logic signed [DATA_W-1:0]  D_MAX    = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic signed [DATA_W-1:0]  D_MIN    = {1'b1, {(DATA_W - 1){1'b0}}};

    // Memories
    logic signed [DATA_W-1:0] coef_mem [CDEPTH];
    logic signed [DATA_W-1:0] dly_mem  [DDEPTH];

    // Registers
    logic [COUNT_W-1:0]       count_reg;
    logic [CADDR_W-1:0]       clr_cnt_reg;
    logic [OP_W-1:0]          item_op_reg;
    logic [SEC_FIELD_W-1:0]   item_sec_reg;
    logic [SLOT_W-1:0]        item_slot_reg;
    logic signed [DATA_W-1:0] item_value_reg;
    logic [SEC_W-1:0]         sec_reg, sec_next;
    logic [SEC_W-1:0]         wr_sec_reg;
    logic                     wr_valid_reg, wr_valid_next;
    logic                     sat_reg, sat_next;
    logic                     rd_ok_reg;
    logic signed [DATA_W-1:0] x_reg, x_next;
    logic signed [DATA_W-1:0] y_reg, y_next;
    logic signed [DATA_W-1:0] coef_rd_reg;
    logic signed [DATA_W-1:0] dly_rd_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  acc1_reg, acc1_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_data_reg;
    logic                     out_sat_reg;

    // Combinational signals
    logic                     accept;
    logic                     out_free;
    logic                     push;
    logic [W_S-1:0]           n_eff;
    logic [W_S-1:0]           count_ext;
    logic [W_S-1:0]           rd_sec;
    logic [W_S-1:0]           item_sec_w;
    logic                     item_ok;
    logic [W_S-1:0]           dsel_sec;
    logic                     dsel_slot;
    logic [IDX_W-1:0]         c_rd_idx;
    logic [IDX_W-1:0]         c_item_idx;
    logic [W_S:0]             d_rd_idx;
    logic [W_S:0]             d_item_idx;
    logic [SEC_W:0]           d_z_idx;
    logic                     c_re;
    logic                     d_re;
    logic                     c_load_we;
    logic                     d_load_we;
    logic                     d_clr_we;
    logic                     z_we;
    logic                     c_we;
    logic [CADDR_W-1:0]       c_waddr;
    logic signed [DATA_W-1:0] c_wdata;
    logic                     d_we;
    logic [DADDR_W-1:0]       d_waddr;
    logic signed [DATA_W-1:0] d_wdata;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [ACC_W-1:0]  dly_q52;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  rnd_src;
    logic signed [ACC_W-1:0]  rnd_sum;
    logic signed [Q_W-1:0]    rnd_q;
    logic                     clip_hi;
    logic                     clip_lo;
    logic signed [DATA_W-1:0] rnd_val;
    logic                     rnd_used;

    // Handshakes and status towards the sequencer.
    assign accept   = in_valid & ctl.ready;
    assign out_free = ~out_valid_reg | out_ready;
    assign push     = ctl.push & out_free;

    // Sections in use: zero counts as one, above the build size as all.
    assign count_ext = W_S'(count_reg);
    always_comb
    begin
        priority if (count_reg == '0)
            n_eff = W_S'(1);
        else if (count_ext > SEC_LIM)
            n_eff = SEC_LIM;
        else
            n_eff = count_ext;
    end

    assign stat.clr_done = (clr_cnt_reg == CLR_LAST);
    assign stat.last     = (W_S'(sec_reg) >= n_eff);
    assign stat.out_free = out_free;
    assign stat.op       = item_op_reg;

    // Read and write addresses; the first reads of a sample are from section zero.
    assign rd_sec     = ctl.init ? '0 : W_S'(sec_reg) + W_S'(ctl.rd_next);
    assign item_sec_w = W_S'(item_sec_reg);
    assign item_ok    = (item_sec_w < SEC_LIM);
    assign c_rd_idx   = IDX_W'({rd_sec, 2'b00}) + IDX_W'(rd_sec) + IDX_W'(ctl.coef_slot);
    assign c_item_idx = IDX_W'({item_sec_w, 2'b00}) + IDX_W'(item_sec_w)
                        + IDX_W'(item_slot_reg);
    assign dsel_sec   = ctl.rd_item ? item_sec_w : rd_sec;
    assign dsel_slot  = ctl.rd_item ? item_slot_reg[0] : ctl.dly_slot;
    assign d_rd_idx   = {dsel_sec, dsel_slot};
    assign d_item_idx = {item_sec_w, item_slot_reg[0]};
    assign d_z_idx    = {wr_sec_reg, ctl.z_slot};

    assign c_re = ctl.coef_rd & (rd_sec < SEC_LIM);
    assign d_re = ctl.dly_rd & (dsel_sec < SEC_LIM)
                  & (~ctl.rd_item | (item_slot_reg < SLOT_W'(DELAYS)));

    // Write sources: clearing pass, loads, and the filter writeback.
    assign c_load_we = ctl.disp_wr & (item_op_reg == OP_LOAD_COEF) & item_ok
                       & (item_slot_reg < SLOT_W'(COEFS));
    assign d_load_we = ctl.disp_wr & (item_op_reg == OP_LOAD_DELAY) & item_ok
                       & (item_slot_reg < SLOT_W'(DELAYS));
    assign d_clr_we  = ctl.clr & (clr_cnt_reg < DLY_END);
    assign z_we      = ctl.z_wr & wr_valid_reg;

    assign c_we    = ctl.clr | c_load_we;
    assign c_waddr = ctl.clr ? clr_cnt_reg : c_item_idx[CADDR_W-1:0];
    assign c_wdata = ctl.clr ? '0 : item_value_reg;

    assign d_we = d_clr_we | d_load_we | z_we;
    always_comb
    begin
        priority if (d_clr_we)
        begin
            d_waddr = clr_cnt_reg[DADDR_W-1:0];
            d_wdata = '0;
        end
        else if (z_we)
        begin
            d_waddr = d_z_idx[DADDR_W-1:0];
            d_wdata = rnd_val;
        end
        else
        begin
            d_waddr = d_item_idx[DADDR_W-1:0];
            d_wdata = item_value_reg;
        end
    end

    // Coefficient memory with registered read.
    always_ff @(posedge clk)
    begin
        if (c_we)
            coef_mem[c_waddr] <= c_wdata;
        if (c_re)
            coef_rd_reg <= coef_mem[c_rd_idx[CADDR_W-1:0]];
    end

    // Delay memory with registered read.
    always_ff @(posedge clk)
    begin
        if (d_we)
            dly_mem[d_waddr] <= d_wdata;
        if (d_re)
            dly_rd_reg <= dly_mem[d_rd_idx[DADDR_W-1:0]];
    end

    // Multiplier: coefficient times section input or section output.
    assign mul_b = ctl.mul_y ? y_reg : x_reg;
    always_ff @(posedge clk)
    begin
        prod_reg <= coef_rd_reg * mul_b;
    end

    // Accumulators hold the exact Q14.52 sums.
    assign dly_q52  = {{(ACC_W - DATA_W - COEF_FRAC){dly_rd_reg[DATA_W-1]}},
                       dly_rd_reg, {COEF_FRAC{1'b0}}};
    assign prod_ext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        unique case (ctl.acc_op)
            ACC_LOAD_DLY: acc_next = dly_q52;
            ACC_ADD:      acc_next = acc_reg + prod_ext;
            ACC_DLY_ADD:  acc_next = dly_q52 + prod_ext;
            ACC_SUB:      acc_next = acc_reg - prod_ext;
            default:      acc_next = acc_reg;
        endcase
        unique case (ctl.acc1_op)
            ACC1_LOAD: acc1_next = prod_ext;
            ACC1_SUB:  acc1_next = acc1_reg - prod_ext;
            default:   acc1_next = acc1_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        acc1_reg <= acc1_next;
    end

    // Round half up to Q8.24, then saturate to 32 bits.
    assign rnd_src = ctl.rnd_alt ? acc1_reg : acc_reg;
    assign rnd_sum = rnd_src + RND_HALF;
    assign rnd_q   = rnd_sum[ACC_W-1:COEF_FRAC];
    assign clip_hi = (rnd_q > Q_MAX);
    assign clip_lo = (rnd_q < Q_MIN);
    always_comb
    begin
        priority if (clip_hi)
            rnd_val = D_MAX;
        else if (clip_lo)
            rnd_val = D_MIN;
        else
            rnd_val = rnd_q[DATA_W-1:0];
    end
    assign rnd_used = ctl.y_ld | z_we;

    // Section sequencing and sample registers.
    always_comb
    begin
        sec_next      = sec_reg;
        wr_valid_next = wr_valid_reg;
        sat_next      = sat_reg | (rnd_used & (clip_hi | clip_lo));
        x_next        = x_reg;
        y_next        = y_reg;
        if (ctl.init)
        begin
            sec_next      = '0;
            wr_valid_next = 1'b0;
            sat_next      = 1'b0;
            x_next        = item_value_reg;
        end
        if (ctl.adv)
        begin
            sec_next      = sec_reg + SEC_W'(1);
            wr_valid_next = 1'b1;
            x_next        = y_reg;
        end
        if (ctl.y_ld)
            y_next = rnd_val;
        if (ctl.rd_load)
        begin
            y_next   = rd_ok_reg ? dly_rd_reg : '0;
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        if (ctl.adv)
            wr_sec_reg <= sec_reg;
        if (ctl.rd_item)
            rd_ok_reg <= d_re;
        if (accept)
        begin
            item_sec_reg   <= in_section;
            item_slot_reg  <= in_slot;
            item_value_reg <= in_value;
        end
        if (push)
        begin
            out_data_reg <= y_reg;
            out_sat_reg  <= sat_reg;
        end
    end

    // Control state.
    assign out_valid_next = push | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= COUNT_W'(1);
            clr_cnt_reg   <= '0;
            item_op_reg   <= OP_FILTER;
            sec_reg       <= '0;
            wr_valid_reg  <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                count_reg <= cfg_data;
            if (ctl.clr && !stat.clr_done)
                clr_cnt_reg <= clr_cnt_reg + CADDR_W'(1);
            if (accept)
                item_op_reg <= in_op;
            sec_reg       <= sec_next;
            wr_valid_reg  <= wr_valid_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign out_saturated = out_sat_reg;

    // At most one source writes the delay memory in a cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({d_clr_we, d_load_we, z_we}))
        else $error("delay memory write sources collide");

    // At most one source writes the coefficient memory in a cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.clr, c_load_we}))
        else $error("coefficient memory write sources collide");

    // Writeback only goes to a section the loop has already passed.
    assert property (@(posedge clk) disable iff (!rst_n)
        z_we |-> (wr_sec_reg < sec_reg))
        else $error("delay writeback to a section not yet finished");

endmodule

// File: rtl/biquad_section_cascade_top.sv
// ----------------------------------------------------------------------------
// Biquad section cascade
// Cascade of second-order IIR sections in transposed direct form II with
// Q8.24 samples and delays and Q4.28 coefficients.
// ----------------------------------------------------------------------------
// After reset the block clears its coefficient and delay memories and takes
// no word in that time. A filter word then occupies the block from acceptance
// until its result is pushed: the single multiplier forms the five products
// of each section in use in the steps S0..S4 of the control program, and the
// last section's delay writeback adds a tail of the steps S0 and S1. A
// coefficient or delay load returns to idle after the dispatch step, a delay
// read runs the steps RD0, RD1 and the result step. The next word is taken
// while a result still waits in the output register. The saturation flag
// reports whether any section output or delay of that sample was clipped.
module biquad_section_cascade_top #(
    parameter int SECTIONS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    bqc_item_if.sink                     item,
    bqc_result_if.source                 result,
    input  logic                         cfg_we,
    input  logic [bqc_pkg::COUNT_W-1:0]  cfg_data
);
    import bqc_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    // Program sequencer.
    bqc_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .stat     (stat),
        .ctl      (ctl)
    );

    // Arithmetic, storage and output register.
    bqc_datapath #(
        .SECTIONS (SECTIONS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .in_valid      (item.valid),
        .in_op         (item.op),
        .in_section    (item.section),
        .in_slot       (item.slot),
        .in_value      (item.value),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .out_data      (result.data),
        .out_saturated (result.saturated)
    );

    // Words are taken only in the idle step.
    assign item.ready = ctl.ready;

endmodule
